// File: sv/gbs_pkg.sv
package gbs_pkg;

  localparam int DEF_MAX_COLS = 32;
  localparam int DEF_MAX_ROWS = 32;

  // Internal width for grid dimensions and coordinates; holds up to 256 plus one step.
  localparam int DIM_W  = 9;
  localparam int PROD_W = 2 * DIM_W;

  localparam int CFG_ADDR_W = 3;
  localparam int CFG_DATA_W = 6;
  localparam int DIMREG_W   = 6;
  localparam int MODE_W     = 2;
  localparam int COORD_W    = 5;
  localparam int STATUS_W   = 3;
  localparam int ID_W       = 10;

  typedef enum logic [CFG_ADDR_W-1:0] {
    CFG_GRID_WIDTH   = 3'd0,
    CFG_GRID_HEIGHT  = 3'd1,
    CFG_START_COL    = 3'd2,
    CFG_START_ROW    = 3'd3,
    CFG_GOAL_COL     = 3'd4,
    CFG_GOAL_ROW     = 3'd5,
    CFG_SEARCH_ORDER = 3'd6
  } cfg_index_t;

  typedef enum logic [MODE_W-1:0] {
    MODE_CELL   = 2'd0,
    MODE_FILL   = 2'd1,
    MODE_BEGIN  = 2'd2,
    MODE_EXPAND = 2'd3
  } mode_t;

  typedef enum logic [STATUS_W-1:0] {
    STAT_ACK       = 3'd0,
    STAT_VISIT     = 3'd1,
    STAT_GOAL      = 3'd2,
    STAT_EMPTY     = 3'd3,
    STAT_NO_SEARCH = 3'd4
  } status_t;

  typedef enum logic [3:0] {
    S_IDLE,
    S_CELL_RD,
    S_CELL_WR,
    S_FILL,
    S_BEGIN,
    S_POP,
    S_NODE,
    S_CHECK,
    S_LEFT,
    S_RIGHT,
    S_UP,
    S_DOWN
  } state_t;

endpackage

// File: sv/gbs_map_ram.sv
module gbs_map_ram #(
  parameter int AW     = 5,
  parameter int WORD_W = 32,
  parameter bit FILL   = 1'b0
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              clear,
  input  logic              rd_en,
  input  logic [AW-1:0]     rd_addr,
  output logic [WORD_W-1:0] rd_word,
  input  logic              wr_en,
  input  logic [AW-1:0]     wr_addr,
  input  logic [WORD_W-1:0] wr_word
);
  localparam int DEPTH = 1 << AW;

  logic [WORD_W-1:0] mem [DEPTH];
  logic [DEPTH-1:0]  valid;
  logic [DEPTH-1:0]  valid_next;
  logic [WORD_W-1:0] rd_q;
  logic              rd_vld;

  // A row that was never written since the last clear reads as the fill value.
  // A write in the same cycle as a clear still marks its own row.
  always_comb begin
    valid_next = clear ? '0 : valid;
    if (wr_en) begin
      valid_next[wr_addr] = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= '0;
    end else begin
      valid <= valid_next;
    end
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_word;
    end
    if (rd_en) begin
      rd_q   <= mem[rd_addr];
      rd_vld <= valid[rd_addr];
    end
  end

  assign rd_word = rd_vld ? rd_q : {WORD_W{FILL}};

endmodule

// File: sv/gbs_list_ram.sv
module gbs_list_ram #(
  parameter int AW = 10,
  parameter int DW = 10
) (
  input  logic          clk,
  input  logic          wr_en,
  input  logic [AW-1:0] wr_addr,
  input  logic [DW-1:0] wr_data,
  input  logic          rd_en,
  input  logic [AW-1:0] rd_addr,
  output logic [DW-1:0] rd_data
);
  localparam int DEPTH = 1 << AW;

  logic [DW-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

// File: sv/gbs_cell_test.sv
module gbs_cell_test #(
  parameter int RW = 5
) (
  input  logic                       exists,
  input  logic [gbs_pkg::DIM_W-1:0]  tcol,
  input  logic [gbs_pkg::DIM_W-1:0]  trow,
  input  logic [gbs_pkg::DIM_W-1:0]  grid_w,
  input  logic [gbs_pkg::DIM_W-1:0]  grid_h,
  input  logic [(1 << RW)-1:0]       open_word,
  input  logic [(1 << RW)-1:0]       seen_word,
  output logic                       take,
  output logic [(1 << RW)-1:0]       marked
);
  import gbs_pkg::*;

  localparam int WORD_W = 1 << RW;

  logic [RW-1:0]     idx;
  logic [WORD_W-1:0] onehot;

  assign idx    = trow[RW-1:0];
  assign onehot = {{(WORD_W-1){1'b0}}, 1'b1} << idx;

  // The grid in use never exceeds storage, so the grid bounds also cover storage bounds.
  assign take = exists && (tcol < grid_w) && (trow < grid_h)
                && open_word[idx] && !seen_word[idx];

  assign marked = seen_word | onehot;

endmodule

// File: sv/grid_bfs_dfs_search.sv
// Grid search engine for breadth-first or depth-first search on a 4-connected grid.
// A request is taken when start is high and busy is low; exactly one result follows,
// shown for one cycle while done is high, and it must be captured then because the
// block cannot be held off. An expand that does not stop at a missing search, an empty
// worklist or the end cell reads the three map columns around the node one after
// another through a single read port and tests the four neighbours one per cycle in
// one shared test unit, each push taking the single worklist write port. The next
// request may be taken in the cycle that done is high. The maps keep one valid bit
// per column, so a clear resets only those bits with no pass over the memory, and no
// clearing pass follows reset.
module grid_bfs_dfs_search #(
  parameter int MAX_COLS = gbs_pkg::DEF_MAX_COLS,
  parameter int MAX_ROWS = gbs_pkg::DEF_MAX_ROWS
) (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           cfg_we,
  input  logic [gbs_pkg::CFG_ADDR_W-1:0] cfg_addr,
  input  logic [gbs_pkg::CFG_DATA_W-1:0] cfg_wdata,
  input  logic                           start,
  output logic                           busy,
  input  logic [gbs_pkg::MODE_W-1:0]     mode,
  input  logic [gbs_pkg::COORD_W-1:0]    cell_col,
  input  logic [gbs_pkg::COORD_W-1:0]    cell_row,
  input  logic                           cell_open,
  output logic                           done,
  output logic [gbs_pkg::STATUS_W-1:0]   status,
  output logic [gbs_pkg::COORD_W-1:0]    node_col,
  output logic [gbs_pkg::COORD_W-1:0]    node_row,
  output logic [gbs_pkg::ID_W-1:0]       node_id
);
  import gbs_pkg::*;

  localparam int CW     = $clog2(MAX_COLS);
  localparam int RW     = $clog2(MAX_ROWS);
  localparam int LW     = CW + RW;
  localparam int CNT_W  = LW + 1;
  localparam int WORD_W = 1 << RW;
  localparam logic [DIM_W-1:0] COLS_LIM = DIM_W'(MAX_COLS);
  localparam logic [DIM_W-1:0] ROWS_LIM = DIM_W'(MAX_ROWS);

  function automatic logic [DIM_W-1:0] eff_dim(input logic [DIMREG_W-1:0] raw,
                                               input logic [DIM_W-1:0] lim);
    logic [DIM_W-1:0] r;
    r = DIM_W'(raw);
    if (r == '0) begin
      r = DIM_W'(1);
    end else if (r > lim) begin
      r = lim;
    end
    return r;
  endfunction

  function automatic logic [DIM_W-1:0] clamp_dim(input logic [COORD_W-1:0] v,
                                                 input logic [DIM_W-1:0] lim);
    logic [DIM_W-1:0] r;
    r = DIM_W'(v);
    if (r > lim - DIM_W'(1)) begin
      r = lim - DIM_W'(1);
    end
    return r;
  endfunction

  // Configuration registers
  logic [DIMREG_W-1:0] grid_width;
  logic [DIMREG_W-1:0] grid_height;
  logic [COORD_W-1:0]  start_col;
  logic [COORD_W-1:0]  start_row;
  logic [COORD_W-1:0]  goal_col;
  logic [COORD_W-1:0]  goal_row;
  logic                search_order;

  state_t state, state_next;

  logic [COORD_W-1:0] in_col;
  logic [COORD_W-1:0] in_row;
  logic               in_open;
  logic [LW-1:0]      head;
  logic [CNT_W-1:0]   count;
  logic               searching;
  logic [CW-1:0]      ncol;
  logic [RW-1:0]      nrow;
  logic [ID_W-1:0]    nid;
  logic [WORD_W-1:0]  seen_mod;

  logic [DIM_W-1:0] w_eff, h_eff;
  logic [DIM_W-1:0] ncol9, nrow9;
  logic [DIM_W-1:0] sc9, sr9, gc9, gr9;
  logic [DIM_W-1:0] in_col9, in_row9;
  logic             cell_in_range;
  logic             at_goal;

  assign w_eff   = eff_dim(grid_width, COLS_LIM);
  assign h_eff   = eff_dim(grid_height, ROWS_LIM);
  assign ncol9   = DIM_W'(ncol);
  assign nrow9   = DIM_W'(nrow);
  assign sc9     = clamp_dim(start_col, w_eff);
  assign sr9     = clamp_dim(start_row, h_eff);
  assign gc9     = clamp_dim(goal_col, w_eff);
  assign gr9     = clamp_dim(goal_row, h_eff);
  assign in_col9 = DIM_W'(in_col);
  assign in_row9 = DIM_W'(in_row);
  assign cell_in_range = (in_col9 < COLS_LIM) && (in_row9 < ROWS_LIM);
  assign at_goal = (ncol9 == gc9) && (nrow9 == gr9);

  // Memory ports
  logic              map_rd_en;
  logic [CW-1:0]     map_rd_addr;
  logic [WORD_W-1:0] open_rd, seen_rd;
  logic              open_wr_en, open_clear;
  logic [WORD_W-1:0] open_wr_word;
  logic              seen_wr_en, seen_clear;
  logic [CW-1:0]     seen_wr_addr;
  logic [WORD_W-1:0] seen_wr_word;
  logic [WORD_W-1:0] in_bit, start_word;

  logic              list_rd_en;
  logic [LW-1:0]     list_rd;
  logic              push_en, begin_push;
  logic [LW-1:0]     push_id;
  logic [LW-1:0]     list_wr_addr;

  logic              t_exists, t_take;
  logic [DIM_W-1:0]  t_col, t_row;
  logic [WORD_W-1:0] t_seen, t_marked;

  logic              fin;
  status_t           fin_status;

  logic [CW-1:0]     rd_col;
  logic [RW-1:0]     rd_row;
  logic [PROD_W-1:0] id_full;

  assign in_bit       = {{(WORD_W-1){1'b0}}, 1'b1} << in_row9[RW-1:0];
  assign start_word   = {{(WORD_W-1){1'b0}}, 1'b1} << sr9[RW-1:0];
  assign open_wr_word = in_open ? (open_rd | in_bit) : (open_rd & ~in_bit);

  assign rd_col  = list_rd[LW-1:RW];
  assign rd_row  = list_rd[RW-1:0];
  assign id_full = PROD_W'(DIM_W'(rd_col)) * PROD_W'(h_eff) + PROD_W'(DIM_W'(rd_row));

  // A depth-first push goes in front of the head, a breadth-first one behind the tail.
  always_comb begin
    if (begin_push) begin
      list_wr_addr = search_order ? '1 : '0;
    end else if (search_order) begin
      list_wr_addr = head - LW'(1);
    end else begin
      list_wr_addr = head + count[LW-1:0];
    end
  end

  gbs_map_ram #(.AW(CW), .WORD_W(WORD_W), .FILL(1'b1)) u_open_map (
    .clk     (clk),
    .rst     (rst),
    .clear   (open_clear),
    .rd_en   (map_rd_en),
    .rd_addr (map_rd_addr),
    .rd_word (open_rd),
    .wr_en   (open_wr_en),
    .wr_addr (in_col9[CW-1:0]),
    .wr_word (open_wr_word)
  );

  gbs_map_ram #(.AW(CW), .WORD_W(WORD_W), .FILL(1'b0)) u_seen_map (
    .clk     (clk),
    .rst     (rst),
    .clear   (seen_clear),
    .rd_en   (map_rd_en),
    .rd_addr (map_rd_addr),
    .rd_word (seen_rd),
    .wr_en   (seen_wr_en),
    .wr_addr (seen_wr_addr),
    .wr_word (seen_wr_word)
  );

  gbs_list_ram #(.AW(LW), .DW(LW)) u_worklist (
    .clk     (clk),
    .wr_en   (push_en),
    .wr_addr (list_wr_addr),
    .wr_data (push_id),
    .rd_en   (list_rd_en),
    .rd_addr (head),
    .rd_data (list_rd)
  );

  gbs_cell_test #(.RW(RW)) u_cell_test (
    .exists    (t_exists),
    .tcol      (t_col),
    .trow      (t_row),
    .grid_w    (w_eff),
    .grid_h    (h_eff),
    .open_word (open_rd),
    .seen_word (t_seen),
    .take      (t_take),
    .marked    (t_marked)
  );

  // Next state
  always_comb begin
    state_next = state;
    case (state)
      S_IDLE: begin
        if (start) begin
          case (mode)
            MODE_CELL:  state_next = S_CELL_RD;
            MODE_FILL:  state_next = S_FILL;
            MODE_BEGIN: state_next = S_BEGIN;
            default:    state_next = S_POP;
          endcase
        end
      end
      S_CELL_RD: state_next = S_CELL_WR;
      S_CELL_WR: state_next = S_IDLE;
      S_FILL:    state_next = S_IDLE;
      S_BEGIN:   state_next = S_IDLE;
      S_POP:     state_next = (searching && (count != '0)) ? S_NODE : S_IDLE;
      S_NODE:    state_next = S_CHECK;
      S_CHECK:   state_next = at_goal ? S_IDLE : S_LEFT;
      S_LEFT:    state_next = S_RIGHT;
      S_RIGHT:   state_next = S_UP;
      S_UP:      state_next = S_DOWN;
      S_DOWN:    state_next = S_IDLE;
      default:   state_next = S_IDLE;
    endcase
  end

  // Control outputs per state
  always_comb begin
    map_rd_en    = 1'b0;
    map_rd_addr  = ncol;
    open_wr_en   = 1'b0;
    open_clear   = 1'b0;
    seen_wr_en   = 1'b0;
    seen_clear   = 1'b0;
    seen_wr_addr = ncol;
    seen_wr_word = t_marked;
    list_rd_en   = 1'b0;
    push_en      = 1'b0;
    begin_push   = 1'b0;
    push_id      = {ncol, nrow};
    t_exists     = 1'b0;
    t_col        = ncol9;
    t_row        = nrow9;
    t_seen       = seen_rd;
    fin          = 1'b0;
    fin_status   = STAT_ACK;
    case (state)
      S_CELL_RD: begin
        map_rd_en   = 1'b1;
        map_rd_addr = in_col9[CW-1:0];
      end
      S_CELL_WR: begin
        open_wr_en = cell_in_range;
        fin        = 1'b1;
      end
      S_FILL: begin
        open_clear = 1'b1;
        fin        = 1'b1;
      end
      S_BEGIN: begin
        // The start cell is pushed even when it is blocked.
        seen_clear   = 1'b1;
        seen_wr_en   = 1'b1;
        seen_wr_addr = sc9[CW-1:0];
        seen_wr_word = start_word;
        push_en      = 1'b1;
        begin_push   = 1'b1;
        push_id      = {sc9[CW-1:0], sr9[RW-1:0]};
        fin          = 1'b1;
      end
      S_POP: begin
        if (!searching) begin
          fin        = 1'b1;
          fin_status = STAT_NO_SEARCH;
        end else if (count == '0) begin
          fin        = 1'b1;
          fin_status = STAT_EMPTY;
        end else begin
          list_rd_en = 1'b1;
        end
      end
      S_CHECK: begin
        if (at_goal) begin
          fin        = 1'b1;
          fin_status = STAT_GOAL;
        end else begin
          map_rd_en   = 1'b1;
          map_rd_addr = ncol - CW'(1);
        end
      end
      S_LEFT: begin
        t_exists     = (ncol != '0);
        t_col        = ncol9 - DIM_W'(1);
        seen_wr_en   = t_take;
        seen_wr_addr = ncol - CW'(1);
        push_en      = t_take;
        push_id      = {ncol - CW'(1), nrow};
        map_rd_en    = 1'b1;
        map_rd_addr  = ncol + CW'(1);
      end
      S_RIGHT: begin
        t_exists     = 1'b1;
        t_col        = ncol9 + DIM_W'(1);
        seen_wr_en   = t_take;
        seen_wr_addr = ncol + CW'(1);
        push_en      = t_take;
        push_id      = {ncol + CW'(1), nrow};
        map_rd_en    = 1'b1;
        map_rd_addr  = ncol;
      end
      S_UP: begin
        t_exists   = (nrow != '0);
        t_row      = nrow9 - DIM_W'(1);
        seen_wr_en = t_take;
        push_en    = t_take;
        push_id    = {ncol, nrow - RW'(1)};
      end
      S_DOWN: begin
        // The node's own column may already carry the bit set for the cell above.
        t_exists   = 1'b1;
        t_row      = nrow9 + DIM_W'(1);
        t_seen     = seen_mod;
        seen_wr_en = t_take;
        push_en    = t_take;
        push_id    = {ncol, nrow + RW'(1)};
        fin        = 1'b1;
        fin_status = STAT_VISIT;
      end
      default: begin
      end
    endcase
  end

  assign busy = (state != S_IDLE);

  // Control state
  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= S_IDLE;
      done         <= 1'b0;
      head         <= '0;
      count        <= '0;
      searching    <= 1'b0;
      grid_width   <= DIMREG_W'(32);
      grid_height  <= DIMREG_W'(32);
      start_col    <= '0;
      start_row    <= '0;
      goal_col     <= COORD_W'(31);
      goal_row     <= COORD_W'(31);
      search_order <= 1'b0;
    end else begin
      state <= state_next;
      done  <= fin;
      if (cfg_we) begin
        case (cfg_addr)
          CFG_GRID_WIDTH:   grid_width   <= cfg_wdata;
          CFG_GRID_HEIGHT:  grid_height  <= cfg_wdata;
          CFG_START_COL:    start_col    <= cfg_wdata[COORD_W-1:0];
          CFG_START_ROW:    start_row    <= cfg_wdata[COORD_W-1:0];
          CFG_GOAL_COL:     goal_col     <= cfg_wdata[COORD_W-1:0];
          CFG_GOAL_ROW:     goal_row     <= cfg_wdata[COORD_W-1:0];
          CFG_SEARCH_ORDER: search_order <= cfg_wdata[0];
          default: begin
          end
        endcase
      end
      case (state)
        S_BEGIN: begin
          head      <= search_order ? '1 : '0;
          count     <= CNT_W'(1);
          searching <= 1'b1;
        end
        S_POP: begin
          if (searching) begin
            if (count == '0) begin
              searching <= 1'b0;
            end else begin
              head  <= head + LW'(1);
              count <= count - CNT_W'(1);
            end
          end
        end
        S_CHECK: begin
          if (at_goal) begin
            searching <= 1'b0;
          end
        end
        default: begin
          if (push_en) begin
            if (search_order) begin
              head <= head - LW'(1);
            end
            count <= count + CNT_W'(1);
          end
        end
      endcase
    end
  end

  // Payload registers
  always_ff @(posedge clk) begin
    if (state == S_IDLE && start) begin
      in_col  <= cell_col;
      in_row  <= cell_row;
      in_open <= cell_open;
    end
    if (state == S_NODE) begin
      ncol <= rd_col;
      nrow <= rd_row;
      nid  <= id_full[ID_W-1:0];
    end
    if (state == S_UP) begin
      seen_mod <= t_take ? t_marked : seen_rd;
    end
    if (fin) begin
      status <= fin_status;
      if (fin_status == STAT_VISIT || fin_status == STAT_GOAL) begin
        node_col <= ncol9[COORD_W-1:0];
        node_row <= nrow9[COORD_W-1:0];
        node_id  <= nid;
      end else begin
        node_col <= '0;
        node_row <= '0;
        node_id  <= '0;
      end
    end
  end

  a_done_after_work: assert property (@(posedge clk) disable iff (rst)
    done |-> $past(busy))
    else $error("result strobe without a request in progress");

  a_accept_busy: assert property (@(posedge clk) disable iff (rst)
    (start && !busy) |=> busy)
    else $error("accepted request did not make the block busy");

  a_goal_stops: assert property (@(posedge clk) disable iff (rst)
    (done && status == STAT_GOAL) |-> !searching)
    else $error("search still running after the end cell was reached");

  a_no_search: assert property (@(posedge clk) disable iff (rst)
    (state == S_POP && !searching) |=> (done && status == STAT_NO_SEARCH))
    else $error("expand without a search gave the wrong result");

  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    count <= CNT_W'(1 << LW))
    else $error("worklist count beyond storage");

endmodule
